FILE: hdl/assert_macros.svh
// Assertion macros for the checker file of the window maximum block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge while the block is out of reset.
`define SWM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define SWM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: hdl/swm_pkg.sv
// Shared types, constants and helpers of the sliding window maximum block.
package swm_pkg;

    localparam int WINDOW_MAX_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 32;
    localparam int POS_W           = 16;
    localparam int WS_W            = 7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BACK,
        ST_FRONT,
        ST_HEAD,
        ST_PUSH
    } swm_state_t;

    // Result strobe from the sequencer to the output register.
    typedef struct packed {
        logic valid;
        logic last;
    } swm_res_t;

    // A window size of zero acts as one; sizes above the deque depth are clipped.
    function automatic logic [WS_W-1:0] eff_window(input logic [WS_W-1:0] ws,
                                                   input int wmax);
        logic [WS_W-1:0] k;
        if (ws == '0) begin
            k = WS_W'(1);
        end else if (int'(ws) > wmax) begin
            k = WS_W'(wmax);
        end else begin
            k = ws;
        end
        return k;
    endfunction

endpackage

FILE: hdl/swm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module swm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/swm_cmp.sv
// Shared magnitude comparator: a <= b, signed or unsigned.
module swm_cmp #(
    parameter int W = 32
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    input  logic         signed_mode,
    output logic         le
);

    logic [W-1:0] flip;

    // Flipping the sign bit turns a two's complement compare into an unsigned one.
    assign flip = signed_mode ? {1'b1, {(W-1){1'b0}}} : '0;
    assign le   = (a ^ flip) <= (b ^ flip);

endmodule

FILE: hdl/swm_ctrl.sv
// Sequencer of the window maximum block: deque pointers and per-item steps.
module swm_ctrl #(
    parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF,
    parameter int CMP_W       = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input item
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [SAMPLE_BITS-1:0]        in_value,
    input  logic                          in_last,
    input  logic [swm_pkg::WS_W-1:0]      window_size,
    // result
    input  logic                          out_free,
    output swm_pkg::swm_res_t             res,
    output logic [SAMPLE_BITS-1:0]        res_value,
    // deque store
    output logic                          ram_wr_en,
    output logic [$clog2(WINDOW_MAX)-1:0] ram_wr_addr,
    output logic [swm_pkg::POS_W+SAMPLE_BITS-1:0] ram_wr_data,
    output logic [$clog2(WINDOW_MAX)-1:0] ram_rd_addr,
    input  logic [swm_pkg::POS_W+SAMPLE_BITS-1:0] ram_rd_data,
    // shared comparator
    output logic [CMP_W-1:0]              cmp_a,
    output logic [CMP_W-1:0]              cmp_b,
    output logic                          cmp_signed,
    input  logic                          cmp_le
);

    import swm_pkg::*;

    localparam int PTR_W = $clog2(WINDOW_MAX);
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        return (int'(p) + 1 >= WINDOW_MAX) ? '0 : PTR_W'(int'(p) + 1);
    endfunction

    function automatic logic [PTR_W-1:0] prev_slot(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_W'(WINDOW_MAX - 1) : PTR_W'(int'(p) - 1);
    endfunction

    swm_state_t             state_reg, state_next;
    logic [PTR_W-1:0]       head_reg, head_next;
    logic [PTR_W-1:0]       tail_reg, tail_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic                   filled_reg, filled_next;
    logic [SAMPLE_BITS-1:0] value_reg, value_next;
    logic                   last_reg, last_next;
    logic [WS_W-1:0]        k_reg, k_next;
    logic [SAMPLE_BITS-1:0] front_reg, front_next;

    logic [SAMPLE_BITS-1:0] rd_value;
    logic [POS_W-1:0]       rd_pos;
    logic [POS_W-1:0]       age;
    logic                   accept;
    logic                   drop;
    logic                   push_go;
    logic [CNT_W-1:0]       count_less;

    assign rd_value   = ram_rd_data[SAMPLE_BITS-1:0];
    assign rd_pos     = ram_rd_data[POS_W+SAMPLE_BITS-1:SAMPLE_BITS];
    assign age        = pos_reg - rd_pos;
    assign accept     = in_valid && in_ready;
    assign count_less = count_reg - CNT_W'(1);
    // A front entry leaves if it is out of the window or the deque is full.
    assign drop       = cmp_le || (int'(count_reg) >= WINDOW_MAX);
    assign push_go    = !(filled_reg || cmp_le) || out_free;

    // Comparator operand selection.
    always_comb begin
        cmp_a      = CMP_W'($signed(rd_value));
        cmp_b      = CMP_W'($signed(value_reg));
        cmp_signed = 1'b1;
        case (state_reg)
            ST_FRONT: begin
                cmp_a      = CMP_W'(k_reg);
                cmp_b      = CMP_W'(age);
                cmp_signed = 1'b0;
            end
            ST_PUSH: begin
                cmp_a      = CMP_W'(k_reg);
                cmp_b      = CMP_W'({1'b0, pos_reg} + 17'd1);
                cmp_signed = 1'b0;
            end
            default: begin
                cmp_signed = 1'b1;
            end
        endcase
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = (count_reg != '0) ? ST_BACK : ST_PUSH;
                end
            end
            ST_BACK: begin
                if (cmp_le) begin
                    state_next = (count_less != '0) ? ST_BACK : ST_PUSH;
                end else begin
                    state_next = ST_FRONT;
                end
            end
            ST_FRONT: begin
                if (drop && (count_less != '0)) begin
                    state_next = ST_HEAD;
                end else begin
                    state_next = ST_PUSH;
                end
            end
            ST_HEAD: begin
                state_next = ST_PUSH;
            end
            ST_PUSH: begin
                if (push_go) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath updates and outputs.
    always_comb begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        filled_next = filled_reg;
        value_next  = value_reg;
        last_next   = last_reg;
        k_next      = k_reg;
        front_next  = front_reg;
        in_ready    = 1'b0;
        ram_rd_addr = head_reg;
        ram_wr_en   = 1'b0;
        ram_wr_addr = tail_reg;
        ram_wr_data = {pos_reg, value_reg};
        res         = '0;
        res_value   = (count_reg == '0) ? value_reg : front_reg;
        case (state_reg)
            ST_IDLE: begin
                // Ready is always high here, so valid alone marks the accepting edge.
                in_ready    = 1'b1;
                ram_rd_addr = prev_slot(tail_reg);
                if (in_valid) begin
                    value_next = in_value;
                    last_next  = in_last;
                    k_next     = eff_window(window_size, WINDOW_MAX);
                end
            end
            ST_BACK: begin
                if (cmp_le) begin
                    tail_next   = prev_slot(tail_reg);
                    count_next  = count_less;
                    ram_rd_addr = prev_slot(prev_slot(tail_reg));
                end else begin
                    ram_rd_addr = head_reg;
                end
            end
            ST_FRONT: begin
                if (drop) begin
                    head_next   = next_slot(head_reg);
                    count_next  = count_less;
                    ram_rd_addr = next_slot(head_reg);
                end else begin
                    front_next = rd_value;
                end
            end
            ST_HEAD: begin
                front_next = rd_value;
            end
            ST_PUSH: begin
                if (push_go) begin
                    ram_wr_en   = 1'b1;
                    tail_next   = next_slot(tail_reg);
                    count_next  = count_reg + CNT_W'(1);
                    filled_next = filled_reg || cmp_le;
                    pos_next    = pos_reg + POS_W'(1);
                    res.valid   = filled_reg || cmp_le;
                    res.last    = last_reg;
                    if (last_reg) begin
                        head_next   = '0;
                        tail_next   = '0;
                        count_next  = '0;
                        pos_next    = '0;
                        filled_next = 1'b0;
                    end
                end
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            pos_reg    <= '0;
            filled_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            pos_reg    <= pos_next;
            filled_reg <= filled_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        last_reg  <= last_next;
        k_reg     <= k_next;
        front_reg <= front_next;
    end

endmodule

FILE: hdl/sliding_window_maximum.sv
// Top level of the sliding window maximum block over a stream of signed samples.
//
//  Channel   Direction  Handshake          Payload
//  s_*       in         s_tvalid/s_tready  s_tdata: sample_value; s_tlast: last_of_array
//  m_*       out        m_tvalid/m_tready  m_tdata: window_max;   m_tlast: end_of_array
//  cfg_*     in         cfg_wr_en          cfg_wr_data: window_size
//
// An item goes from idle through back steps (one compare per back removal against the
// registered read port of the deque memory), a front step and, after a front removal,
// a head step to the push step, each only while the deque holds entries; the shared
// comparator settles one step a cycle. The result register frees the input side: a new
// item is taken while a result still waits. If a result is due and the register is
// still full, the item waits in its final step until m_tready. Synchronous active-low
// reset empties the deque and sets the window size to one; no clearing pass is needed.
module sliding_window_maximum #(
    parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Configuration: window_size.
    input  logic                                 cfg_wr_en,
    input  logic [swm_pkg::WS_W-1:0]             cfg_wr_data,
    // Input items. s_tdata fields from bit 0: sample_value, then zero padding.
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_tdata,
    input  logic                                 s_tlast,
    // Result items. m_tdata fields from bit 0: window_max, then zero padding.
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] m_tdata,
    output logic                                 m_tlast
);

    import swm_pkg::*;

    localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int PTR_W   = $clog2(WINDOW_MAX);
    localparam int ENTRY_W = POS_W + SAMPLE_BITS;
    // The comparator must also hold a position plus one.
    localparam int CMP_W   = (SAMPLE_BITS > POS_W + 1) ? SAMPLE_BITS : POS_W + 1;

    logic [WS_W-1:0]        window_size_reg;
    logic                   m_valid_reg;
    logic                   m_last_reg;
    logic [SAMPLE_BITS-1:0] m_value_reg;

    swm_res_t               res;
    logic [SAMPLE_BITS-1:0] res_value;
    logic                   out_free;

    logic                   ram_wr_en;
    logic [PTR_W-1:0]       ram_wr_addr;
    logic [ENTRY_W-1:0]     ram_wr_data;
    logic [PTR_W-1:0]       ram_rd_addr;
    logic [ENTRY_W-1:0]     ram_rd_data;

    logic [CMP_W-1:0]       cmp_a;
    logic [CMP_W-1:0]       cmp_b;
    logic                   cmp_signed;
    logic                   cmp_le;

    // The result register is free when empty or when its item leaves this cycle.
    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_size_reg <= WS_W'(1);
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                window_size_reg <= cfg_wr_data;
            end
            if (res.valid) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (res.valid) begin
            m_value_reg <= res_value;
            m_last_reg  <= res.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = TDATA_W'(m_value_reg);
    assign m_tlast  = m_last_reg;

    swm_ctrl #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS),
        .CMP_W       (CMP_W)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_value    (s_tdata[SAMPLE_BITS-1:0]),
        .in_last     (s_tlast),
        .window_size (window_size_reg),
        .out_free    (out_free),
        .res         (res),
        .res_value   (res_value),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .cmp_a       (cmp_a),
        .cmp_b       (cmp_b),
        .cmp_signed  (cmp_signed),
        .cmp_le      (cmp_le)
    );

    // Deque store: each entry holds a candidate's position above its value.
    swm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (WINDOW_MAX)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    swm_cmp #(
        .W (CMP_W)
    ) u_cmp (
        .a           (cmp_a),
        .b           (cmp_b),
        .signed_mode (cmp_signed),
        .le          (cmp_le)
    );

endmodule

FILE: hdl/swm_checker.sv
// Port-level assertions for the sliding window maximum block, bound to its top level.
`include "assert_macros.svh"

module swm_checker #(
    parameter int TDATA_W = 32
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata,
    input logic               m_tlast
);

    logic [TDATA_W+1:0] m_bus;

    assign m_bus = {m_tvalid, m_tlast, m_tdata};

    // Reset leaves no result pending.
    `SWM_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "result valid after reset")

    // A waiting result keeps its contents.
    `SWM_ASSERT(a_out_hold, m_tvalid && !m_tready |=> $stable(m_bus), "stalled result changed")

    // The block works on one item at a time.
    `SWM_ASSERT(a_busy_after_accept, s_tvalid && s_tready |=> !s_tready, "ready after accept")

    // A new result only comes out of an item in progress.
    `SWM_ASSERT(a_result_from_work, $rose(m_tvalid) |-> $past(!s_tready), "result while idle")

endmodule

bind sliding_window_maximum swm_checker #(.TDATA_W(TDATA_W)) u_swm_checker (.*);
